>>> rtl/form_field_extractor_defines.svh
// Assertion macros for the form field extractor.
// No dependencies; included by the modules that check themselves.
`ifndef FORM_FIELD_EXTRACTOR_DEFINES_SVH
`define FORM_FIELD_EXTRACTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define FFX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define FFX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFX_ASSERT(lbl, prop, msg)
`define FFX_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/ffx_pkg.sv
// Shared types, character codes and helpers of the form field extractor.
// No dependencies; imported by every module of the block.
package ffx_pkg;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [4:0]  KEY_LEN_RESET  = 5'd4;
	localparam logic [8:0]  CAPACITY_RESET = 9'd64;

	typedef enum logic [3:0] {
		PH_MATCH = 4'b0001,
		PH_SKIP  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_HIGH = 2'd1,
		ESC_LOW  = 2'd2
	} esc_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_FOUND   = 3'd1,
		ST_BAD_ESCAPE  = 3'd2,
		ST_DECODED_NUL = 3'd3,
		ST_NO_ROOM     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_KEY_LOW  = 2'd0,
		CFG_KEY_HIGH = 2'd1,
		CFG_KEY_LEN  = 2'd2,
		CFG_CAPACITY = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value_byte;
		status_t    status;
	} result_t;

	typedef struct packed {
		logic    v0;
		result_t r0;
		logic    v1;
		result_t r1;
	} result_pair_t;

	typedef struct packed {
		logic [127:0] key;
		logic [4:0]   key_length;
		logic [8:0]   capacity;
	} cfg_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic result_t make_value(input logic [7:0] b);
		result_t r;
		r.kind       = 1'b0;
		r.value_byte = b;
		r.status     = ST_OK;
		return r;
	endfunction

	function automatic result_t make_verdict(input status_t s);
		result_t r;
		r.kind       = 1'b1;
		r.value_byte = 8'd0;
		r.status     = s;
		return r;
	endfunction

endpackage

>>> rtl/ffx_core.sv
// Per-byte parse and decode: pair state, key match, escape decode, verdicts.
// Depends on ffx_pkg and form_field_extractor_defines.svh.
`include "form_field_extractor_defines.svh"
module ffx_core #(
	parameter int KEY_MAX = 16,
	parameter int OUT_MAX = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffx_pkg::cfg_t        cfg,
	input  logic                 fire,
	input  logic [7:0]           data_byte,
	input  logic                 last,
	input  logic                 no_byte,
	output ffx_pkg::result_pair_t res
);
	import ffx_pkg::*;

	localparam int KIW = $clog2(KEY_MAX + 1);
	localparam int KSW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int CW  = $clog2(OUT_MAX + 1);

	phase_t          phase_q, phase_d;
	logic [KIW-1:0]  key_index_q, key_index_d;
	logic [CW-1:0]   value_count_q, value_count_d;
	esc_t            esc_q, esc_d;
	logic [3:0]      high_q, high_d;

	logic [7:0]      key_arr [KEY_MAX];
	logic [7:0]      key_sel;
	logic [KIW-1:0]  klen;
	logic [CW-1:0]   eff_cap;
	logic            cap_zero;
	logic [4:0]      hx;
	logic [7:0]      esc_byte;
	logic            put_v;
	logic [7:0]      put_b;
	logic            a_v, b_v, c_v;
	result_t         a, b, c;

	always_comb begin
		for (int i = 0; i < KEY_MAX; i++)
			key_arr[i] = cfg.key[i*8 +: 8];
	end

	assign key_sel = key_arr[key_index_q[KSW-1:0]];

	always_comb begin
		if (cfg.key_length > 5'(KEY_MAX))
			klen = KIW'(KEY_MAX);
		else
			klen = KIW'(cfg.key_length);
		if (32'(cfg.capacity) > 32'(OUT_MAX))
			eff_cap = CW'(OUT_MAX);
		else
			eff_cap = CW'(cfg.capacity);
	end

	assign cap_zero = (eff_cap == '0);
	assign hx       = hex_digit(data_byte);
	assign esc_byte = {high_q, hx[3:0]};

	always_comb begin
		phase_d       = phase_q;
		key_index_d   = key_index_q;
		value_count_d = value_count_q;
		esc_d         = esc_q;
		high_d        = high_q;
		a_v   = 1'b0;
		b_v   = 1'b0;
		c_v   = 1'b0;
		a     = make_verdict(ST_NO_ROOM);
		b     = make_verdict(ST_OK);
		c     = make_verdict(ST_OK);
		put_v = 1'b0;
		put_b = 8'd0;
		if (fire) begin
			if (phase_d != PH_DONE && cap_zero && (!no_byte || last)) begin
				a_v     = 1'b1;
				phase_d = PH_DONE;
			end
			if (!no_byte) begin
				case (phase_d)
					PH_MATCH: begin
						if (data_byte == CH_AMP) begin
							key_index_d = '0;
						end else if (key_index_q < klen) begin
							if (data_byte == key_sel)
								key_index_d = key_index_q + 1'b1;
							else
								phase_d = PH_SKIP;
						end else if (data_byte == CH_EQ) begin
							phase_d       = PH_VALUE;
							value_count_d = '0;
							esc_d         = ESC_NONE;
						end else begin
							phase_d = PH_SKIP;
						end
					end
					PH_SKIP: begin
						if (data_byte == CH_AMP) begin
							phase_d     = PH_MATCH;
							key_index_d = '0;
						end
					end
					PH_VALUE: begin
						if (esc_q != ESC_NONE) begin
							if (!hx[4]) begin
								b_v     = 1'b1;
								b       = make_verdict(ST_BAD_ESCAPE);
								phase_d = PH_DONE;
							end else if (esc_q == ESC_HIGH) begin
								high_d = hx[3:0];
								esc_d  = ESC_LOW;
							end else begin
								esc_d = ESC_NONE;
								if (esc_byte == 8'd0) begin
									b_v     = 1'b1;
									b       = make_verdict(ST_DECODED_NUL);
									phase_d = PH_DONE;
								end else begin
									put_v = 1'b1;
									put_b = esc_byte;
								end
							end
						end else if (data_byte == CH_AMP) begin
							b_v     = 1'b1;
							b       = make_verdict(ST_OK);
							phase_d = PH_DONE;
						end else if (data_byte == CH_PCT) begin
							esc_d = ESC_HIGH;
						end else if (data_byte == CH_PLUS) begin
							put_v = 1'b1;
							put_b = CH_SPACE;
						end else begin
							put_v = 1'b1;
							put_b = data_byte;
						end
						if (put_v) begin
							if (({1'b0, value_count_q} + (CW+1)'(1)) >= {1'b0, eff_cap}) begin
								b_v     = 1'b1;
								b       = make_verdict(ST_NO_ROOM);
								phase_d = PH_DONE;
							end else begin
								b_v           = 1'b1;
								b             = make_value(put_b);
								value_count_d = value_count_q + 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (last) begin
				if (phase_d == PH_VALUE) begin
					c_v = 1'b1;
					c   = make_verdict((esc_d != ESC_NONE) ? ST_BAD_ESCAPE : ST_OK);
				end else if (phase_d != PH_DONE) begin
					c_v = 1'b1;
					c   = make_verdict(ST_NOT_FOUND);
				end
				phase_d       = PH_MATCH;
				key_index_d   = '0;
				value_count_d = '0;
				esc_d         = ESC_NONE;
				high_d        = 4'd0;
			end
		end
	end

	// at most two of the three sources fire in one transaction
	always_comb begin
		res.v0 = a_v | b_v | c_v;
		res.r0 = a_v ? a : (b_v ? b : c);
		res.v1 = a_v ? (b_v | c_v) : (b_v & c_v);
		res.r1 = a_v ? (b_v ? b : c) : c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_MATCH;
			key_index_q   <= '0;
			value_count_q <= '0;
			esc_q         <= ESC_NONE;
			high_q        <= 4'd0;
		end else if (fire) begin
			phase_q       <= phase_d;
			key_index_q   <= key_index_d;
			value_count_q <= value_count_d;
			esc_q         <= esc_d;
			high_q        <= high_d;
		end
	end

	`FFX_ASSERT(a_second_needs_first, res.v1 |-> res.v0, "second result without first")
	`FFX_ASSERT(a_second_is_verdict, res.v1 |-> res.r1.kind, "second result is not a verdict")
	`FFX_ASSERT(a_last_clears, fire && last |=> phase_q == PH_MATCH && key_index_q == '0,
		"body end did not clear state")
	`FFX_ASSERT(a_no_result_idle, !fire |-> !res.v0, "result without transaction")

endmodule

>>> rtl/ffx_out_fifo.sv
// Four-entry result queue: up to two pushes per cycle, one pop.
// Depends on ffx_pkg and form_field_extractor_defines.svh.
`include "form_field_extractor_defines.svh"
module ffx_out_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ffx_pkg::result_pair_t push,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ffx_pkg::result_t      out_res
);
	import ffx_pkg::*;

	result_t     mem_q [4];
	logic [1:0]  wptr_q, rptr_q;
	logic [2:0]  count_q;
	logic        pop;
	logic [2:0]  n_push;

	assign room      = (count_q <= 3'd2);
	assign out_valid = (count_q != 3'd0);
	assign out_res   = mem_q[rptr_q];
	assign pop       = out_valid && !out_stall;
	assign n_push    = 3'(push.v0) + 3'(push.v1);

	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wptr_q] <= push.r0;
		if (push.v1)
			mem_q[wptr_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 2'd0;
			rptr_q  <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wptr_q  <= wptr_q + n_push[1:0];
			rptr_q  <= rptr_q + 2'(pop);
			count_q <= count_q + n_push - 3'(pop);
		end
	end

	`FFX_ASSERT(a_count_bound, count_q <= 3'd4, "result queue count out of range")
	`FFX_ASSERT(a_push_with_room, push.v0 |-> count_q <= 3'd2, "push into full result queue")
	`FFX_ASSERT(a_ptr_gap, (count_q == 3'd0 || count_q == 3'd4) |-> wptr_q == rptr_q,
		"queue pointers disagree with count")

endmodule

>>> rtl/form_field_extractor.sv
// Top level of the form field extractor: config registers, input register,
// parse core and result queue. Depends on ffx_pkg, ffx_core, ffx_out_fifo.
//
// channel  | handshake                 | payload
// body     | body_valid / body_stall   | data_byte, last, no_byte
// result   | result_valid / result_stall | kind, value_byte, status
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One body byte per cycle unless body_stall is high; the input register
// passes a byte's results to the queue once it has room, and the first can
// leave on the next cycle. The combinational parse core sets the rate.
// An item may yield two results; the four-entry queue absorbs that.
// Reset is asynchronous; registers return to key 0, key_length 4, capacity 64.
// body_stall rises only while the input register holds an item and the queue
// lacks room for two results.
`include "form_field_extractor_defines.svh"
module form_field_extractor #(
	parameter int KEY_MAX = 16,
	parameter int OUT_MAX = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        body_valid,
	output logic        body_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic        no_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [7:0]  value_byte,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import ffx_pkg::*;

	cfg_t         cfg_q;
	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         last_s1;
	logic         no_byte_s1;
	logic         room;
	logic         fire;
	result_pair_t pair;
	result_t      out_res;

	assign cfg_ready  = 1'b1;
	assign fire       = valid_s1 && room;
	assign body_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key        <= '0;
			cfg_q.key_length <= KEY_LEN_RESET;
			cfg_q.capacity   <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KEY_LOW:  cfg_q.key[63:0]   <= cfg_data;
				CFG_KEY_HIGH: cfg_q.key[127:64] <= cfg_data;
				CFG_KEY_LEN:  cfg_q.key_length  <= cfg_data[4:0];
				CFG_CAPACITY: cfg_q.capacity    <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!body_stall)
			valid_s1 <= body_valid;
	end

	always_ff @(posedge clk) begin
		if (!body_stall && body_valid) begin
			data_s1    <= data_byte;
			last_s1    <= last;
			no_byte_s1 <= no_byte;
		end
	end

	ffx_core #(
		.KEY_MAX(KEY_MAX),
		.OUT_MAX(OUT_MAX)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.data_byte (data_s1),
		.last      (last_s1),
		.no_byte   (no_byte_s1),
		.res       (pair)
	);

	ffx_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pair),
		.room      (room),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_res   (out_res)
	);

	assign kind       = out_res.kind;
	assign value_byte = out_res.value_byte;
	assign status     = out_res.status;

	`FFX_ASSERT(a_stall_needs_item, body_stall |-> valid_s1, "stall with empty input register")
	`FFX_ASSERT(a_item_moves, valid_s1 && room |=> !body_stall || $past(body_valid),
		"input register did not drain")
	`FFX_ASSERT(a_stall_only_full, body_stall |-> !room, "stall while queue has room")

endmodule
